>>> hw/rtl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keyframe table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

   localparam int MAX_KEYS_DEF   = 64;
   localparam int TIME_FRAC_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   localparam int POS_BITS   = 16;
   localparam int IDX_BITS   = 6;
   localparam int TIME_BITS  = 24;
   localparam int OUT_BITS   = 32;
   localparam int TOTAL_BITS = 7;
   localparam int CNT_BITS   = 11;
   localparam int CMP_BITS   = 40;
   localparam int WIDE_BITS  = 64;
   localparam int DVS_BITS   = 33;
   localparam int MUL_STEPS  = TIME_BITS;
   localparam int DIV_STEPS  = WIDE_BITS;
   localparam int ITER_BITS  = 7;

   typedef enum logic [2:0] {
      OP_QUERY  = 3'd0,
      OP_INSERT = 3'd1,
      OP_MOVE   = 3'd2,
      OP_DELETE = 3'd3,
      OP_SET    = 3'd4,
      OP_READ   = 3'd5,
      OP_CLEAR  = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type                   opcode;
      logic [IDX_BITS-1:0]          key_index;
      logic [POS_BITS-1:0]          key_position;
      logic signed [OUT_BITS-1:0]   key_value;
      logic [TIME_BITS-1:0]         query_time;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0]   result_value;
      logic [POS_BITS-1:0]          result_position;
      logic [TOTAL_BITS-1:0]        key_total;
      status_type                   status;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SET
   } cell_op_type;

   typedef struct packed {
      cell_op_type                  op;
      logic [POS_BITS-1:0]          pos;
      logic signed [OUT_BITS-1:0]   val;
      logic [IDX_BITS-1:0]          idx;
      logic [IDX_BITS-1:0]          lim;
      logic [CNT_BITS-1:0]          count;
      logic [TIME_BITS-1:0]         time_q;
   } cell_cmd_type;

   typedef struct packed {
      logic                         any_b;
      logic                         any_a;
      logic [POS_BITS-1:0]          b_pos;
      logic signed [OUT_BITS-1:0]   b_val;
      logic [POS_BITS-1:0]          a_pos;
      logic signed [OUT_BITS-1:0]   a_val;
      logic [POS_BITS-1:0]          r_pos;
      logic signed [OUT_BITS-1:0]   r_val;
   } gather_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE2,
      S_PREP,
      S_MUL,
      S_NORM,
      S_DIV,
      S_FIN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/keyframe_table_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_table_interpolator
// Sorted keyframe table in a row of cells, with a shift-add multiplier and a
// restoring divider for linear interpolation between neighbor keys.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  req      in         req_valid / req_stall    req_data (req_type)
//  rsp      out        rsp_valid / rsp_stall    rsp_data (rsp_type)
//  csr      in         csr_wr_en                csr_wr_data (interp_mode)
//
//  table edits, reads, hold queries: accept, execute, deliver
//  move: a remove pass then an insert pass through the cell row
//  linear query: runs the 24-step multiplier and then the
//  64-step divider, one bit per cycle each
//  reset clears the key count and sets linear mode; the table is not cleared
//  a stalled rsp beat holds in the output register while the next req is taken
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_table_interpolator #(
   parameter int MAX_KEYS       = kti_pkg::MAX_KEYS_DEF,
   parameter int TIME_FRAC_BITS = kti_pkg::TIME_FRAC_DEF,
   parameter int VALUE_BITS     = kti_pkg::VALUE_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  kti_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output kti_pkg::rsp_type    rsp_data,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data
);

   localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int CW = kti_pkg::CNT_BITS;
   localparam int WB = kti_pkg::WIDE_BITS;
   localparam int DB = kti_pkg::DVS_BITS;

   kti_pkg::state_type   state_ff, state_in;
   kti_pkg::req_type     req_ff, req_in;
   kti_pkg::rsp_type     res_ff, res_in;
   kti_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 mode_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [kti_pkg::OUT_BITS-1:0] keep_ff, keep_in;
   logic [kti_pkg::POS_BITS-1:0]        b_pos_ff, b_pos_in, a_pos_ff, a_pos_in;
   logic signed [kti_pkg::OUT_BITS-1:0] b_val_ff, b_val_in, a_val_ff, a_val_in;
   logic signed [WB-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [kti_pkg::TIME_BITS-1:0] mplier_ff, mplier_in;
   logic [WB-1:0]        dvd_ff, dvd_in;
   logic [DB-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [kti_pkg::ITER_BITS-1:0] iter_ff, iter_in;

   kti_pkg::cell_cmd_type cmd;
   kti_pkg::gather_type   g;
   kti_pkg::gather_type   cell_g [MAX_KEYS];
   logic [kti_pkg::POS_BITS-1:0] pos_w [MAX_KEYS];
   logic signed [SW-1:0]         val_w [MAX_KEYS];
   logic                         ahead_w [MAX_KEYS];
   logic                         le_w [MAX_KEYS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
         kti_cell #(
            .INDEX     (gi),
            .TIME_FRAC (TIME_FRAC_BITS),
            .VAL_BITS  (SW)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .left_pos    ((gi == 0) ? cmd.pos : pos_w[(gi == 0) ? 0 : gi-1]),
            .left_val    ((gi == 0) ? cmd.val[SW-1:0] : val_w[(gi == 0) ? 0 : gi-1]),
            .left_ahead  ((gi == 0) ? 1'b1 : ahead_w[(gi == 0) ? 0 : gi-1]),
            .left_le     ((gi == 0) ? 1'b1 : le_w[(gi == 0) ? 0 : gi-1]),
            .right_pos   (pos_w[(gi == MAX_KEYS-1) ? gi : gi+1]),
            .right_val   (val_w[(gi == MAX_KEYS-1) ? gi : gi+1]),
            .right_le    ((gi == MAX_KEYS-1) ? 1'b0 : le_w[(gi == MAX_KEYS-1) ? gi : gi+1]),
            .pos         (pos_w[gi]),
            .val         (val_w[gi]),
            .ahead       (ahead_w[gi]),
            .le          (le_w[gi]),
            .gather      (cell_g[gi])
         );
      end
   endgenerate

   always_comb begin
      g = '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         g = kti_pkg::gather_type'(g | cell_g[i]);
      end
   end

   logic                 bad;
   logic signed [WB-1:0] trial_n;
   logic [DB:0]          trial_d;
   logic signed [WB-1:0] fl;
   logic [DB-1:0]        rm;
   logic signed [WB-1:0] s;
   logic [kti_pkg::CMP_BITS-1:0] num_w, den_w;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      keep_in      = keep_ff;
      b_pos_in     = b_pos_ff;
      b_val_in     = b_val_ff;
      a_pos_in     = a_pos_ff;
      a_val_in     = a_val_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      iter_in      = iter_ff;

      cmd.op     = kti_pkg::CELL_HOLD;
      cmd.pos    = req_ff.key_position;
      cmd.val    = req_ff.key_value;
      cmd.idx    = req_ff.key_index;
      cmd.lim    = '0;
      cmd.count  = count_ff;
      cmd.time_q = req_ff.query_time;

      bad     = CW'(req_ff.key_index) >= count_ff;
      num_w   = kti_pkg::CMP_BITS'(req_ff.query_time) -
                (kti_pkg::CMP_BITS'(b_pos_ff) << TIME_FRAC_BITS);
      den_w   = (kti_pkg::CMP_BITS'(a_pos_ff) - kti_pkg::CMP_BITS'(b_pos_ff))
                << TIME_FRAC_BITS;
      trial_n = (acc_ff <<< 1) + WB'(dvs_ff >> 1);
      trial_d = {rem_ff, dvd_ff[WB-1]};
      fl      = '0;
      rm      = '0;
      s       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         kti_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               res_in   = '0;
               state_in = kti_pkg::S_EXEC;
            end
         end
         kti_pkg::S_EXEC: begin
            state_in = kti_pkg::S_DONE;
            unique case (req_ff.opcode)
               kti_pkg::OP_QUERY: begin
                  if (count_ff == '0) begin
                     res_in.result_value = '0;
                  end else if (g.any_b && g.any_a && mode_ff) begin
                     b_pos_in = g.b_pos;
                     b_val_in = g.b_val;
                     a_pos_in = g.a_pos;
                     a_val_in = g.a_val;
                     state_in = kti_pkg::S_PREP;
                  end else begin
                     res_in.result_value = g.any_b ? g.b_val : g.a_val;
                  end
               end
               kti_pkg::OP_INSERT: begin
                  if (count_ff >= CW'(MAX_KEYS)) begin
                     res_in.status = kti_pkg::ST_FULL;
                  end else begin
                     cmd.op   = kti_pkg::CELL_INSERT;
                     count_in = count_ff + 1'b1;
                  end
               end
               kti_pkg::OP_MOVE: begin
                  if (bad) begin
                     res_in.status = kti_pkg::ST_RANGE;
                  end else begin
                     cmd.op   = kti_pkg::CELL_REMOVE;
                     keep_in  = g.r_val;
                     count_in = count_ff - 1'b1;
                     state_in = kti_pkg::S_MOVE2;
                  end
               end
               kti_pkg::OP_DELETE: begin
                  if (bad) begin
                     res_in.status = kti_pkg::ST_RANGE;
                  end else begin
                     cmd.op   = kti_pkg::CELL_REMOVE;
                     count_in = count_ff - 1'b1;
                  end
               end
               kti_pkg::OP_SET: begin
                  if (bad) begin
                     res_in.status = kti_pkg::ST_RANGE;
                  end else begin
                     cmd.op = kti_pkg::CELL_SET;
                  end
               end
               kti_pkg::OP_READ: begin
                  if (bad) begin
                     res_in.status = kti_pkg::ST_RANGE;
                  end else begin
                     res_in.result_value    = g.r_val;
                     res_in.result_position = g.r_pos;
                  end
               end
               kti_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         kti_pkg::S_MOVE2: begin
            cmd.op   = kti_pkg::CELL_INSERT;
            cmd.val  = keep_ff;
            cmd.lim  = req_ff.key_index;
            count_in = count_ff + 1'b1;
            state_in = kti_pkg::S_DONE;
         end
         kti_pkg::S_PREP: begin
            mplier_in = num_w[kti_pkg::TIME_BITS-1:0];
            dvs_in    = DB'(den_w << 1);
            mcand_in  = WB'(a_val_ff) - WB'(b_val_ff);
            acc_in    = '0;
            iter_in   = '0;
            state_in  = kti_pkg::S_MUL;
         end
         kti_pkg::S_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            iter_in   = iter_ff + 1'b1;
            if (iter_ff == kti_pkg::ITER_BITS'(kti_pkg::MUL_STEPS - 1)) begin
               state_in = kti_pkg::S_NORM;
            end
         end
         kti_pkg::S_NORM: begin
            neg_in   = trial_n < 0;
            dvd_in   = (trial_n < 0) ? WB'(-trial_n) : WB'(trial_n);
            rem_in   = '0;
            iter_in  = '0;
            state_in = kti_pkg::S_DIV;
         end
         kti_pkg::S_DIV: begin
            if (trial_d >= (DB+1)'(dvs_ff)) begin
               rem_in = DB'(trial_d - (DB+1)'(dvs_ff));
               dvd_in = {dvd_ff[WB-2:0], 1'b1};
            end else begin
               rem_in = DB'(trial_d);
               dvd_in = {dvd_ff[WB-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == kti_pkg::ITER_BITS'(kti_pkg::DIV_STEPS - 1)) begin
               state_in = kti_pkg::S_FIN;
            end
         end
         kti_pkg::S_FIN: begin
            if (neg_ff) begin
               if (rem_ff != '0) begin
                  fl = -$signed(dvd_ff) - 1;
                  rm = dvs_ff - rem_ff;
               end else begin
                  fl = -$signed(dvd_ff);
               end
            end else begin
               fl = $signed(dvd_ff);
               rm = rem_ff;
            end
            s = WB'(b_val_ff) + fl;
            if (s < 0 && rm != '0) begin
               s = s + 1;
            end
            res_in.result_value = s[kti_pkg::OUT_BITS-1:0];
            state_in = kti_pkg::S_DONE;
         end
         kti_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in           = res_ff;
               rsp_data_in.key_total = count_ff[kti_pkg::TOTAL_BITS-1:0];
               rsp_valid_in          = 1'b1;
               state_in              = kti_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kti_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kti_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         mode_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      keep_ff     <= keep_in;
      b_pos_ff    <= b_pos_in;
      b_val_ff    <= b_val_in;
      a_pos_ff    <= a_pos_in;
      a_val_ff    <= a_val_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      iter_ff     <= iter_in;
   end

   assign req_stall = state_ff != kti_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS))
      else $error("key count above table size");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == kti_pkg::S_EXEC)
      else $error("accepted beat not executed");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != kti_pkg::S_EXEC && state_ff != kti_pkg::S_MOVE2)
      |=> $stable(count_ff))
      else $error("key count changed outside an edit");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kti_pkg::S_DONE && res_ff.status == kti_pkg::ST_FULL)
      |-> count_ff == CW'(MAX_KEYS))
      else $error("full status with room left");

endmodule

`default_nettype wire

>>> hw/rtl/kti_cell.sv
// ----------------------------------------------------------------------------
// kti_cell
// One slot of the sorted key row: holds a key, shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_cell #(
   parameter int INDEX     = 0,
   parameter int TIME_FRAC = kti_pkg::TIME_FRAC_DEF,
   parameter int VAL_BITS  = kti_pkg::VALUE_BITS_DEF
) (
   input  wire                                   clock,
   input  kti_pkg::cell_cmd_type                 cmd,
   input  wire [kti_pkg::POS_BITS-1:0]           left_pos,
   input  wire signed [VAL_BITS-1:0]             left_val,
   input  wire                                   left_ahead,
   input  wire                                   left_le,
   input  wire [kti_pkg::POS_BITS-1:0]           right_pos,
   input  wire signed [VAL_BITS-1:0]             right_val,
   input  wire                                   right_le,
   output logic [kti_pkg::POS_BITS-1:0]          pos,
   output logic signed [VAL_BITS-1:0]            val,
   output logic                                  ahead,
   output logic                                  le,
   output kti_pkg::gather_type                   gather
);

   logic [kti_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic signed [VAL_BITS-1:0]   val_ff, val_in;
   logic                         valid;
   logic                         sel_b, sel_a, sel_r;
   logic signed [kti_pkg::OUT_BITS-1:0] val_ext;

   always_comb begin
      valid  = INDEX < int'(cmd.count);
      ahead  = valid && ((pos_ff < cmd.pos) ||
                         ((pos_ff == cmd.pos) && (INDEX < int'(cmd.lim))));
      le     = valid && ((kti_pkg::CMP_BITS'(pos_ff) << TIME_FRAC) <=
                         kti_pkg::CMP_BITS'(cmd.time_q));
      sel_b  = le && !right_le;
      sel_a  = valid && !le && left_le;
      sel_r  = INDEX == int'(cmd.idx);
      val_ext = kti_pkg::OUT_BITS'(val_ff);
      pos    = pos_ff;
      val    = val_ff;

      gather.any_b = le;
      gather.any_a = sel_a;
      gather.b_pos = sel_b ? pos_ff : '0;
      gather.b_val = sel_b ? val_ext : '0;
      gather.a_pos = sel_a ? pos_ff : '0;
      gather.a_val = sel_a ? val_ext : '0;
      gather.r_pos = sel_r ? pos_ff : '0;
      gather.r_val = sel_r ? val_ext : '0;
   end

   always_comb begin
      pos_in = pos_ff;
      val_in = val_ff;
      unique case (cmd.op)
         kti_pkg::CELL_INSERT: begin
            if (!ahead) begin
               if (left_ahead) begin
                  pos_in = cmd.pos;
                  val_in = cmd.val[VAL_BITS-1:0];
               end else begin
                  pos_in = left_pos;
                  val_in = left_val;
               end
            end
         end
         kti_pkg::CELL_REMOVE: begin
            if (INDEX >= int'(cmd.idx)) begin
               pos_in = right_pos;
               val_in = right_val;
            end
         end
         kti_pkg::CELL_SET: begin
            if (sel_r) begin
               val_in = cmd.val[VAL_BITS-1:0];
            end
         end
         kti_pkg::CELL_HOLD: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
   end

endmodule

`default_nettype wire

>>> test/keyframe_table_interpolator_tb.sv
// ----------------------------------------------------------------------------
// keyframe_table_interpolator_tb
// Drives table edits and queries with random gaps and stalls, predicts every
// response from a behavioral copy of the keyframe table and checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_table_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kti_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int FRAC = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   class keyframe_scoreboard;
      logic [15:0] positions[TABLE_DEPTH];
      logic signed [31:0] values[TABLE_DEPTH];
      int count;
      bit linear;
      rsp_type pending[$];
      int mismatches;
      int checked;

      function void clear_table();
         count = 0;
         linear = 1;
         mismatches = 0;
         checked = 0;
         pending.delete();
      endfunction

      function void insert_key(logic [15:0] p, logic signed [31:0] v, int lim);
         int at;
         at = 0;
         while (at < count && (positions[at] < p || (positions[at] == p && at < lim)))
            at++;
         for (int j = count; j > at; j--) begin
            positions[j] = positions[j-1];
            values[j] = values[j-1];
         end
         positions[at] = p;
         values[at] = v;
         count++;
      endfunction

      function void remove_key(int i);
         for (int j = i; j + 1 < count; j++) begin
            positions[j] = positions[j+1];
            values[j] = values[j+1];
         end
         count--;
      endfunction

      function logic signed [31:0] blend(int ib, int ia, longint t);
         longint pb, num, den, d, a, b, q, r, s;
         pb = longint'(positions[ib]) << FRAC;
         num = t - pb;
         den = (longint'(positions[ia]) << FRAC) - pb;
         d = longint'(values[ia]) - longint'(values[ib]);
         a = 2 * d * num + den;
         b = 2 * den;
         q = a / b;
         if ((a % b) != 0 && a < 0)
            q = q - 1;
         r = a - q * b;
         s = longint'(values[ib]) + q;
         if (s < 0 && r > 0)
            s = s + 1;
         return s[31:0];
      endfunction

      function logic signed [31:0] lookup(longint t);
         int nb;
         nb = 0;
         if (count == 0)
            return 0;
         if (count == 1)
            return values[0];
         while (nb < count && (longint'(positions[nb]) << FRAC) <= t)
            nb++;
         if (nb > 0 && nb < count && linear)
            return blend(nb - 1, nb, t);
         if (nb > 0)
            return values[nb-1];
         return values[0];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int idx;
         logic signed [31:0] keep;
         bit bad;
         e = '0;
         e.status = ST_OK;
         idx = r.key_index;
         bad = idx >= count;
         case (r.opcode)
            OP_QUERY: e.result_value = lookup(longint'(r.query_time));
            OP_INSERT: begin
               if (count >= TABLE_DEPTH)
                  e.status = ST_FULL;
               else
                  insert_key(r.key_position, r.key_value, 0);
            end
            OP_MOVE: begin
               if (bad) begin
                  e.status = ST_RANGE;
               end else begin
                  keep = values[idx];
                  remove_key(idx);
                  insert_key(r.key_position, keep, idx);
               end
            end
            OP_DELETE: begin
               if (bad)
                  e.status = ST_RANGE;
               else
                  remove_key(idx);
            end
            OP_SET: begin
               if (bad)
                  e.status = ST_RANGE;
               else
                  values[idx] = r.key_value;
            end
            OP_READ: begin
               if (bad) begin
                  e.status = ST_RANGE;
               end else begin
                  e.result_value = values[idx];
                  e.result_position = positions[idx];
               end
            end
            OP_CLEAR: count = 0;
            default: ;
         endcase
         e.key_total = count[6:0];
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h", got);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.result_value !== e.result_value || got.result_position !== e.result_position ||
             got.key_total !== e.key_total || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected val %0d pos %0d total %0d st %0d",
                        e.result_value, e.result_position, e.key_total, e.status);
               $display("          got val %0d pos %0d total %0d st %0d",
                        got.result_value, got.result_position, got.key_total, got.status);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;

   keyframe_table_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   keyframe_scoreboard board = new();
   int idle_cycles = 0;
   bit hold_off = 0;
   int queries_sent = 0;
   int edits_sent = 0;

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_data);
   end

   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         if (gap != 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && !hold_off)
            @(posedge clock);
      end
   end

   task automatic send_beat(req_type r, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      board.note_request(r);
      if (r.opcode == OP_QUERY)
         queries_sent++;
      else
         edits_sent++;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_op(opcode_type op, int idx, int pos, int val, int t);
      req_type r;
      r.opcode = op;
      r.key_index = idx[5:0];
      r.key_position = pos[15:0];
      r.key_value = val;
      r.query_time = t[23:0];
      send_beat(r, 0);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
      board.linear = m;
   endtask

   function automatic req_type random_request(int pos_span);
      req_type r;
      int pick;
      r.key_index = (board.count > 0 && $urandom_range(0, 9) != 0) ?
                    6'($urandom_range(0, board.count - 1)) : 6'($urandom_range(0, 63));
      r.key_position = (pos_span == 0) ? 16'($urandom()) : 16'($urandom_range(0, pos_span));
      r.key_value = 32'($urandom());
      if ($urandom_range(0, 3) == 0)
         r.key_value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      r.query_time = (pos_span == 0) ? 24'($urandom()) :
                     24'($urandom_range(0, (pos_span + 2) * 256));
      pick = $urandom_range(0, 99);
      if (pick < 35)
         r.opcode = OP_QUERY;
      else if (pick < 60)
         r.opcode = (board.count < 40 || $urandom_range(0, 3) == 0) ? OP_INSERT : OP_DELETE;
      else if (pick < 70)
         r.opcode = OP_MOVE;
      else if (pick < 80)
         r.opcode = OP_DELETE;
      else if (pick < 88)
         r.opcode = OP_SET;
      else if (pick < 97)
         r.opcode = OP_READ;
      else if (pick < 99)
         r.opcode = OP_CLEAR;
      else
         r.opcode = opcode_type'(3'd7);
      return r;
   endfunction

   initial begin
      req_type r;
      board.clear_table();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty table, single key, equal positions, range errors
      send_op(OP_QUERY, 0, 0, 0, 24'hffffff);
      send_op(OP_READ, 0, 0, 0, 0);
      send_op(OP_INSERT, 0, 100, -500, 0);
      send_op(OP_QUERY, 0, 0, 0, 5);
      send_op(OP_INSERT, 0, 100, 7, 0);
      send_op(OP_INSERT, 0, 0, 32'sh80000000, 0);
      send_op(OP_INSERT, 0, 65535, 32'sh7fffffff, 0);
      send_op(OP_READ, 1, 0, 0, 0);
      send_op(OP_QUERY, 0, 0, 0, 50 * 256 + 1);
      send_op(OP_QUERY, 0, 0, 0, 24'hffffff);
      send_op(OP_QUERY, 0, 0, 0, 30000 * 256 + 77);
      send_op(OP_MOVE, 3, 100, 0, 0);
      send_op(OP_MOVE, 0, 100, 0, 0);
      send_op(OP_SET, 2, 0, -3, 0);
      send_op(OP_QUERY, 0, 0, 0, 99 * 256 + 128);
      send_op(OP_MOVE, 63, 1, 0, 0);
      send_op(OP_DELETE, 63, 0, 0, 0);
      send_op(OP_SET, 40, 0, 1, 0);
      send_op(OP_DELETE, 0, 0, 0, 0);
      send_op(opcode_type'(3'd7), 63, 65535, -1, 24'hffffff);
      write_mode(0);
      send_op(OP_QUERY, 0, 0, 0, 0);
      send_op(OP_QUERY, 0, 0, 0, 100 * 256);
      send_op(OP_CLEAR, 0, 0, 0, 0);
      write_mode(1);

      // fill to the top, then a full-table insert
      for (int i = 0; i < 65; i++) begin
         r = random_request(0);
         r.opcode = OP_INSERT;
         send_beat(r, 1);
      end
      send_op(OP_READ, 63, 0, 0, 0);
      hold_off = 1;
      for (int i = 0; i < 20; i++) begin
         r = random_request(0);
         r.opcode = OP_QUERY;
         send_beat(r, 1);
      end

      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase[0]);
         for (int i = 0; i < 280; i++)
            send_beat(random_request(phase < 2 ? 300 : 0), $urandom_range(0, 4) == 0);
      end
      drain();

      $display("covered %0d queries and %0d table edits, both modes, full and empty table",
               queries_sent, edits_sent);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
